// File: src/dtpid_pkg.sv
// dtpid_pkg: shared constants and codes for the drive/turn pid controller
`default_nettype none

package dtpid_pkg;

  localparam int POS_WIDTH_DEF = 24;
  localparam int TGT_IN_W      = 16;
  localparam int TGT_W         = 22;
  localparam int INT_W         = 32;
  localparam int SPD_W         = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_ADDR_W    = 3;
  localparam int USER_IN_W     = 2;

  localparam int DRIVE_TOL   = 5;
  localparam int TURN_TOL    = 32;
  localparam int DRIVE_SHIFT = 8;
  localparam int TURN_SHIFT  = 12;
  localparam int TPI_SHIFT   = 12;

  localparam logic [CFG_W-1:0] DRIVE_KP_RST = 16'd256;
  localparam logic [CFG_W-1:0] DRIVE_KI_RST = 16'd0;
  localparam logic [CFG_W-1:0] DRIVE_KD_RST = 16'd0;
  localparam logic [CFG_W-1:0] TURN_KP_RST  = 16'd256;
  localparam logic [CFG_W-1:0] TURN_KI_RST  = 16'd0;
  localparam logic [CFG_W-1:0] TURN_KD_RST  = 16'd0;
  localparam logic [CFG_W-1:0] TPI_RST      = 16'd7334;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DRIVE_KP = 3'd0,
    REG_DRIVE_KI = 3'd1,
    REG_DRIVE_KD = 3'd2,
    REG_TURN_KP  = 3'd3,
    REG_TURN_KI  = 3'd4,
    REG_TURN_KD  = 3'd5,
    REG_TPI      = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    MODE_DRIVE = 1'b0,
    MODE_TURN  = 1'b1
  } mode_e;

endpackage

`default_nettype wire

// File: src/drive_turn_pid_controller_unit.sv
// drive_turn_pid_controller_unit: differential drive pid tick controller, top level
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: target, 4 encoders, heading
//                                                 tuser: start_req, mode
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: left_speed, right_speed
//                                                 tuser: done_res
//   cfg       in   cfg_we_i                       cfg_addr_i, cfg_wdata_i
//
// one word per cycle while m_axis_tready is high; via input, mid and output registers
// stage one: target scaling, errors, integral and derivative update (controller state)
// stage two: three parallel gain multiplies, round and saturate; then output register
// a stall on m_axis backs up through the stages to s_axis_tready
// reset clears the valid flags and controller state and loads the default gains
`default_nettype none

module drive_turn_pid_controller_unit
  import dtpid_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  localparam int IN_BITS  = TGT_IN_W + 5 * POS_WIDTH,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_W    = 2 * SPD_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // target, left_front_pos, left_rear_pos, right_front_pos, right_rear_pos, heading
  input  wire logic [IN_W-1:0]       s_axis_tdata,
  // start_req, mode
  input  wire logic [USER_IN_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // left_speed, right_speed
  output logic [OUT_W-1:0]           m_axis_tdata,
  // done_res
  output logic [0:0]                 m_axis_tuser,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i
);

  localparam int ERR_W = ((TGT_W > POS_WIDTH) ? TGT_W : POS_WIDTH) + 1;
  localparam int IS_W  = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;
  localparam int SUM_W = (((ERR_W + 18) > (INT_W + 17)) ? (ERR_W + 18) : (INT_W + 17)) + 2;
  localparam int TP_W  = TGT_IN_W + CFG_W + 1;

  localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
  localparam logic signed [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic signed [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};
  localparam logic signed [ERR_W-1:0] DTOL    = ERR_W'(DRIVE_TOL);
  localparam logic signed [ERR_W-1:0] TTOL    = ERR_W'(TURN_TOL);

  typedef struct packed {
    logic                    turn;
    logic                    done;
    logic signed [ERR_W-1:0] e_l;
    logic signed [INT_W-1:0] i_l;
    logic signed [ERR_W:0]   d_l;
    logic signed [ERR_W-1:0] e_r;
    logic signed [INT_W-1:0] i_r;
    logic signed [ERR_W:0]   d_r;
  } mid_t;

  function automatic logic signed [SPD_W-1:0] pid_out(
    input logic signed [ERR_W-1:0] e,
    input logic signed [INT_W-1:0] i,
    input logic signed [ERR_W:0]   d,
    input logic [CFG_W-1:0]        kp,
    input logic [CFG_W-1:0]        ki,
    input logic [CFG_W-1:0]        kd,
    input logic                    turn
  );
    logic signed [ERR_W+CFG_W:0]   pp;
    logic signed [INT_W+CFG_W:0]   pi;
    logic signed [ERR_W+CFG_W+1:0] pd;
    logic signed [SUM_W-1:0]       s;
    logic signed [SUM_W-1:0]       r;
    pp = e * $signed({1'b0, kp});
    pi = i * $signed({1'b0, ki});
    pd = d * $signed({1'b0, kd});
    s  = SUM_W'(pp) + SUM_W'(pi) + SUM_W'(pd);
    if (turn) begin
      r = (s + SUM_W'(1 << (TURN_SHIFT - 1))) >>> TURN_SHIFT;
    end else begin
      r = (s + SUM_W'(1 << (DRIVE_SHIFT - 1))) >>> DRIVE_SHIFT;
    end
    if (r > SUM_W'(SPD_MAX)) begin
      return SPD_MAX;
    end else if (r < SUM_W'(SPD_MIN)) begin
      return SPD_MIN;
    end
    return r[SPD_W-1:0];
  endfunction

  // config registers
  logic [CFG_W-1:0] drive_kp_q, drive_ki_q, drive_kd_q;
  logic [CFG_W-1:0] turn_kp_q, turn_ki_q, turn_kd_q, tpi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_kp_q <= DRIVE_KP_RST;
      drive_ki_q <= DRIVE_KI_RST;
      drive_kd_q <= DRIVE_KD_RST;
      turn_kp_q  <= TURN_KP_RST;
      turn_ki_q  <= TURN_KI_RST;
      turn_kd_q  <= TURN_KD_RST;
      tpi_q      <= TPI_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DRIVE_KP: drive_kp_q <= cfg_wdata_i;
        REG_DRIVE_KI: drive_ki_q <= cfg_wdata_i;
        REG_DRIVE_KD: drive_kd_q <= cfg_wdata_i;
        REG_TURN_KP:  turn_kp_q  <= cfg_wdata_i;
        REG_TURN_KI:  turn_ki_q  <= cfg_wdata_i;
        REG_TURN_KD:  turn_kd_q  <= cfg_wdata_i;
        REG_TPI:      tpi_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake chain
  logic in_valid_q, mid_valid_q, out_valid_q;
  logic out_ready, adv2, mid_ready, adv1, s_accept;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign adv2          = mid_valid_q && out_ready;
  assign mid_ready     = !mid_valid_q || out_ready;
  assign adv1          = in_valid_q && mid_ready;
  assign s_axis_tready = !in_valid_q || mid_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (adv1) begin
        in_valid_q <= 1'b0;
      end
      if (adv1) begin
        mid_valid_q <= 1'b1;
      end else if (adv2) begin
        mid_valid_q <= 1'b0;
      end
      if (adv2) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input register
  logic [IN_BITS-1:0]   in_data_q;
  logic [USER_IN_W-1:0] in_user_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata[IN_BITS-1:0];
      in_user_q <= s_axis_tuser;
    end
  end

  // controller state
  logic                    mode_q;
  logic signed [TGT_W-1:0] tgt_q;
  logic signed [INT_W-1:0] il_q, ir_q;
  logic signed [ERR_W-1:0] pl_q, pr_q;

  // stage one
  logic                        start, eff_mode;
  logic signed [TGT_IN_W-1:0]  tgt_raw;
  logic signed [TP_W-1:0]      tgt_prod, tgt_rnd, tgt_sh;
  logic signed [TGT_W-1:0]     tgt_new, eff_tgt;
  logic signed [INT_W-1:0]     eff_il, eff_ir, il_d, ir_d;
  logic signed [ERR_W-1:0]     eff_pl, eff_pr, pr_d;
  logic signed [POS_WIDTH-1:0] lf, lr, rf, rr, hdg, cur_l, cur_r;
  logic signed [POS_WIDTH:0]   sum_l, sum_r;
  logic signed [ERR_W-1:0]     e_l, e_r;
  logic signed [IS_W-1:0]      isum_l, isum_r;
  logic signed [ERR_W:0]       d_l, d_r;
  logic                        done;
  mid_t                        mid_d, mid_q;

  always_comb begin
    start    = in_user_q[0];
    tgt_raw  = $signed(in_data_q[TGT_IN_W-1:0]);
    lf       = $signed(in_data_q[TGT_IN_W + 0*POS_WIDTH +: POS_WIDTH]);
    lr       = $signed(in_data_q[TGT_IN_W + 1*POS_WIDTH +: POS_WIDTH]);
    rf       = $signed(in_data_q[TGT_IN_W + 2*POS_WIDTH +: POS_WIDTH]);
    rr       = $signed(in_data_q[TGT_IN_W + 3*POS_WIDTH +: POS_WIDTH]);
    hdg      = $signed(in_data_q[TGT_IN_W + 4*POS_WIDTH +: POS_WIDTH]);

    tgt_prod = TP_W'(tgt_raw) * $signed(TP_W'({1'b0, tpi_q}));
    tgt_rnd  = tgt_prod + TP_W'(1 << (TPI_SHIFT - 1));
    tgt_sh   = tgt_rnd >>> TPI_SHIFT;
    tgt_new  = (in_user_q[1] == MODE_TURN) ? TGT_W'(tgt_raw) : tgt_sh[TGT_W-1:0];

    eff_mode = start ? in_user_q[1] : mode_q;
    eff_tgt  = start ? tgt_new : tgt_q;
    eff_il   = start ? '0 : il_q;
    eff_ir   = start ? '0 : ir_q;
    eff_pl   = start ? '0 : pl_q;
    eff_pr   = start ? '0 : pr_q;

    // floor of the encoder pair mean
    sum_l    = (POS_WIDTH+1)'(lf) + (POS_WIDTH+1)'(lr);
    sum_r    = (POS_WIDTH+1)'(rf) + (POS_WIDTH+1)'(rr);
    cur_l    = sum_l[POS_WIDTH:1];
    cur_r    = sum_r[POS_WIDTH:1];

    if (eff_mode == MODE_TURN) begin
      e_l = ERR_W'(eff_tgt) - ERR_W'(hdg);
    end else begin
      e_l = ERR_W'(eff_tgt) - ERR_W'(cur_l);
    end
    e_r = ERR_W'(eff_tgt) - ERR_W'(cur_r);

    isum_l = IS_W'(eff_il) + IS_W'(e_l);
    isum_r = IS_W'(eff_ir) + IS_W'(e_r);
    if (isum_l > IS_W'(INT_MAX)) begin
      il_d = INT_MAX;
    end else if (isum_l < IS_W'(INT_MIN)) begin
      il_d = INT_MIN;
    end else begin
      il_d = isum_l[INT_W-1:0];
    end
    if (eff_mode == MODE_TURN) begin
      ir_d = eff_ir;
      pr_d = eff_pr;
    end else begin
      pr_d = e_r;
      if (isum_r > IS_W'(INT_MAX)) begin
        ir_d = INT_MAX;
      end else if (isum_r < IS_W'(INT_MIN)) begin
        ir_d = INT_MIN;
      end else begin
        ir_d = isum_r[INT_W-1:0];
      end
    end

    d_l = (ERR_W+1)'(e_l) - (ERR_W+1)'(eff_pl);
    d_r = (ERR_W+1)'(e_r) - (ERR_W+1)'(eff_pr);

    if (eff_mode == MODE_TURN) begin
      done = (e_l < TTOL) && (e_l > -TTOL);
    end else begin
      done = (e_l < DTOL) && (e_l > -DTOL) && (e_r < DTOL) && (e_r > -DTOL);
    end

    mid_d.turn = eff_mode;
    mid_d.done = done;
    mid_d.e_l  = e_l;
    mid_d.i_l  = il_d;
    mid_d.d_l  = d_l;
    mid_d.e_r  = e_r;
    mid_d.i_r  = ir_d;
    mid_d.d_r  = d_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DRIVE;
      tgt_q  <= '0;
      il_q   <= '0;
      ir_q   <= '0;
      pl_q   <= '0;
      pr_q   <= '0;
    end else if (adv1) begin
      mode_q <= eff_mode;
      tgt_q  <= eff_tgt;
      il_q   <= il_d;
      ir_q   <= ir_d;
      pl_q   <= e_l;
      pr_q   <= pr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      mid_q <= mid_d;
    end
  end

  // stage two
  logic [CFG_W-1:0]        kp, ki, kd;
  logic signed [SPD_W-1:0] o_l, o_r, spd_l, spd_r;
  logic [OUT_W-1:0]        out_data_d, out_data_q;
  logic                    out_done_q;

  always_comb begin
    kp  = mid_q.turn ? turn_kp_q : drive_kp_q;
    ki  = mid_q.turn ? turn_ki_q : drive_ki_q;
    kd  = mid_q.turn ? turn_kd_q : drive_kd_q;
    o_l = pid_out(mid_q.e_l, mid_q.i_l, mid_q.d_l, kp, ki, kd, mid_q.turn);
    o_r = pid_out(mid_q.e_r, mid_q.i_r, mid_q.d_r, kp, ki, kd, mid_q.turn);
    if (mid_q.done) begin
      spd_l = '0;
      spd_r = '0;
    end else if (mid_q.turn) begin
      spd_l = (o_l == SPD_MIN) ? SPD_MAX : -o_l;
      spd_r = o_l;
    end else begin
      spd_l = o_l;
      spd_r = o_r;
    end
    out_data_d = {spd_r, spd_l};
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      out_data_q <= out_data_d;
      out_done_q <= mid_q.done;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_done_q;

  // checks
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("done word carries nonzero speed");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_q && !mid_valid_q && !out_valid_q) |-> s_axis_tready)
    else $error("empty pipeline refuses input");

  a_turn_right_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv1 && eff_mode == MODE_TURN && !start) |=> ($stable(ir_q) && $stable(pr_q)))
    else $error("turn tick changed right side state");

  a_out_from_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(mid_valid_q))
    else $error("result word without a stage two item");

endmodule

`default_nettype wire
